### sv/ed_pkg.sv
// Shared widths, limits, queue entry type and root unit states for the
// euclidean distance block. No dependencies.
`default_nettype none
package ed_pkg;

  localparam int COORD_W     = 16;
  localparam int MAG_W       = 16;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = 37;
  localparam int RAD_W       = SUM_W + 1;
  localparam int ROOT_W      = RAD_W / 2;
  localparam int REM_W       = ROOT_W + 1;
  localparam int DIST_W      = 18;
  localparam int MAX_DIM_DEF = 16;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             ovf;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FIN
  } back_state_t;

endpackage
`default_nettype wire

### sv/ed_front.sv
// Front end: accepts coordinate beats, counts dimensions, squares and
// accumulates differences, pushes finished sums to the queue. Uses ed_pkg.
`default_nettype none
module ed_front import ed_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_coord_a,
  input  wire logic signed [COORD_W-1:0] in_coord_b,
  input  wire logic                      in_last,
  input  wire logic [QCNT_W-1:0]         q_count,
  output logic                           q_push,
  output job_t                           q_job
);

  localparam int CNT_W = $clog2(MAX_DIM + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;

  logic             s1_valid_r, s1_last_r, s1_add_r, s1_ovf_r;
  logic [MAG_W-1:0] s1_mag_r;
  logic             s2_valid_r, s2_last_r, s2_ovf_r;
  logic [SQ_W-1:0]  s2_sq_r;
  logic [SUM_W-1:0] sum_r, sum_nxt;

  logic                   acc, add_en, ovf_seen;
  logic signed [COORD_W:0] diff;
  logic [COORD_W:0]       mag_full;
  logic [SUM_W:0]         sum_wide;
  logic [SUM_W-1:0]       sum_sat;
  logic [QCNT_W:0]        pending;

  assign pending  = {1'b0, q_count} + (QCNT_W + 1)'(s1_valid_r & s1_last_r)
                  + (QCNT_W + 1)'(s2_valid_r & s2_last_r);
  assign in_ready = pending < (QCNT_W + 1)'(QDEPTH);
  assign acc      = in_valid & in_ready;

  assign add_en   = cnt_r < CNT_W'(MAX_DIM);
  assign ovf_seen = ovf_r | ~add_en;

  assign diff     = {in_coord_a[COORD_W-1], in_coord_a} - {in_coord_b[COORD_W-1], in_coord_b};
  assign mag_full = diff[COORD_W] ? (COORD_W + 1)'(-diff) : (COORD_W + 1)'(diff);

  always_comb begin
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (acc) begin
      if (in_last) begin
        cnt_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        cnt_nxt = add_en ? cnt_r + CNT_W'(1) : cnt_r;
        ovf_nxt = ovf_seen;
      end
    end
  end

  assign sum_wide = {1'b0, sum_r} + (SUM_W + 1)'(s2_sq_r);
  assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

  always_comb begin
    sum_nxt = sum_r;
    q_push  = 1'b0;
    if (s2_valid_r) begin
      q_push  = s2_last_r;
      sum_nxt = s2_last_r ? '0 : sum_sat;
    end
  end

  assign q_job.sum = sum_sat;
  assign q_job.ovf = s2_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      sum_r      <= '0;
    end else begin
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      s1_valid_r <= acc;
      s2_valid_r <= s1_valid_r;
      sum_r      <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_mag_r  <= mag_full[MAG_W-1:0];
      s1_add_r  <= add_en;
      s1_last_r <= in_last;
      s1_ovf_r  <= ovf_seen;
    end
    s2_sq_r   <= s1_add_r ? s1_mag_r * s1_mag_r : '0;
    s2_last_r <= s1_last_r;
    s2_ovf_r  <= s1_ovf_r;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIM))
    else $error("dimension count beyond limit");

endmodule
`default_nettype wire

### sv/ed_fifo.sv
// Short queue of finished sums between the front end and the root unit.
// Uses ed_pkg for the entry type and depth.
`default_nettype none
module ed_fifo import ed_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire job_t        push_job,
  input  wire logic        pop,
  output job_t             pop_job,
  output logic [QCNT_W-1:0] count,
  output logic             nonempty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_r, rd_r;
  logic [QCNT_W-1:0] cnt_r;

  assign count    = cnt_r;
  assign nonempty = cnt_r != '0;
  assign pop_job  = mem[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_r + QPTR_W'(1);
      if (pop)  rd_r <= (rd_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_r + QPTR_W'(1);
      cnt_r <= cnt_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_job;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < QCNT_W'(QDEPTH))
    else $error("queue overrun");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0)
    else $error("queue underrun");

endmodule
`default_nettype wire

### sv/ed_root.sv
// Back end: bit-serial integer square root of a queued sum, one root bit
// per cycle, then saturation into the output register. Uses ed_pkg.
`default_nettype none
module ed_root import ed_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_nonempty,
  input  wire job_t               q_job,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [DIST_W-1:0]       out_distance,
  output logic                    out_overflow
);

  localparam int ITER_W = $clog2(ROOT_W);

  back_state_t state_r, state_nxt;
  logic [ITER_W-1:0] iter_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic              job_ovf_r;
  logic              out_valid_r;
  logic [DIST_W-1:0] out_dist_r;
  logic              out_ovf_r;

  logic              out_load;
  logic [REM_W+1:0]  rem_sh, trial;
  logic              take;
  logic [DIST_W-1:0] dist_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= BK_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_nonempty) begin
          q_pop     = 1'b1;
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (iter_r == ITER_W'(ROOT_W - 1)) state_nxt = BK_FIN;
      end
      BK_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign rem_sh = {rem_r, rad_r[RAD_W-1 -: 2]};
  assign trial  = (REM_W + 2)'({root_r, 2'b01});
  assign take   = rem_sh >= trial;

  assign dist_fin = job_ovf_r ? DIST_MAX :
                    (root_r > ROOT_W'(DIST_MAX)) ? DIST_MAX : root_r[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rad_r     <= {1'b0, q_job.sum};
      rem_r     <= '0;
      root_r    <= '0;
      iter_r    <= '0;
      job_ovf_r <= q_job.ovf;
    end else if (state_r == BK_RUN) begin
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r  <= take ? REM_W'(rem_sh - trial) : rem_sh[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], take};
      iter_r <= iter_r + ITER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_dist_r <= dist_fin;
      out_ovf_r  <= job_ovf_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_overflow = out_ovf_r;

  a_ovf_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ovf_r |-> out_dist_r == DIST_MAX)
    else $error("overflow result not saturated");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == BK_RUN && iter_r == '0)
    else $error("root unit did not start after pop");

endmodule
`default_nettype wire

### sv/euclidean_distance_top.sv
// Euclidean distance engine: one coordinate pair per beat, a result after the
// beat marked last. Instantiates ed_front, ed_fifo and ed_root; uses ed_pkg.
//
// Each beat carries one dimension of two points in signed Q8.8; the block
// accumulates the squared difference and, after the beat marked last, returns
// floor(sqrt(sum)) in unsigned Q10.8 (saturating at 262143). A norm is the
// same stream with in_coord_b held at zero. Dimensions beyond MAX_DIM are
// dropped and the pair's result is 262143 with out_overflow set. Within a
// pair the block takes one beat per cycle while in_ready is high; the square
// and accumulate run in a two-stage pipeline. Each finished sum then goes
// through a two-entry queue to a bit-serial root unit that pops it, computes
// the 19 root bits and loads the output register, taking the next sum only
// after that load. Input stalls only while two finished pairs, queued or
// still in the pipeline, are waiting for the root unit.
`default_nettype none
module euclidean_distance_top import ed_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] in_coord_a,
  input  wire logic signed [COORD_W-1:0] in_coord_b,
  input  wire logic                      in_last,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [DIST_W-1:0]              out_distance,
  output logic                           out_overflow
);

  logic              q_push, q_pop, q_nonempty;
  job_t              push_job, pop_job;
  logic [QCNT_W-1:0] q_count;

  ed_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_coord_a (in_coord_a),
    .in_coord_b (in_coord_b),
    .in_last    (in_last),
    .q_count    (q_count),
    .q_push     (q_push),
    .q_job      (push_job)
  );

  ed_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .count    (q_count),
    .nonempty (q_nonempty)
  );

  ed_root u_root (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_nonempty   (q_nonempty),
    .q_job        (pop_job),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_distance (out_distance),
    .out_overflow (out_overflow)
  );

endmodule
`default_nettype wire
